// ===== sv/tlvfa_pkg.sv =====
`default_nettype none
package tlvfa_pkg;

  localparam int PAYLOAD_BYTES = 64;
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int HEADER_BYTES  = 3;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_NEW_TYPE = 3'd1,
    CMD_ADD_BYTE = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_ABORT    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_LOCKED = 2'd2,
    ST_LINK   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_RESULT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_WRITE  = 2'd2,
    OP_SEND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_WRITE  = 2'd1,
    B_SEND   = 2'd2,
    B_RESULT = 2'd3
  } back_state_t;

  // One job for the back end: up to three store writes, or a send, then a result
  typedef struct packed {
    op_t               op;
    status_t           status;
    logic [CNT_W-1:0]  space;
    logic [1:0]        nw;
    logic [ADDR_W-1:0] wa0;
    logic [ADDR_W-1:0] wa1;
    logic [ADDR_W-1:0] wa2;
    logic [7:0]        wd0;
    logic [7:0]        wd1;
    logic [7:0]        wd2;
    logic [CNT_W-1:0]  count;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/tlv_frame_assembler.sv =====
`default_nettype none
// TLV frame assembler.
// Input channel (in_valid/in_ready) takes one command word: clear, new record
// type, add data byte, send or abort, with the type bytes, data byte and link
// state alongside. Output channel (out_valid/out_ready) gives result words:
// status, byte_valid, frame_byte, last and space_left. A command gives one
// word with last set, except a send of a non-empty buffer, which gives one
// word per filled byte in buffer order with last on the final one.
// cfg_we/cfg_wdata write hold_writes; write it only while the block is idle.
// The front end checks each command against fill count, hold_writes and link
// state, and queues a job (two deep); the back end owns the 64-byte
// store, one write port and one registered read port.
// Each accepted command passes the queue and then the back end. Add byte and
// new type do their store writes there, one store write a cycle, before the
// result word; a send's bytes follow one per cycle while out_ready stays high.
// The queue lets the front take further commands while the back end works.
// Reset empties the buffer, marks every store entry unwritten so that it reads as zero, and clears hold_writes.
// A stalled receiver holds the output word; the back end waits and, once the
// queue is full, in_ready drops.
module tlv_frame_assembler
  import tlvfa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] type_high,
  input  wire logic [7:0] type_low,
  input  wire logic [7:0] data_value,
  input  wire logic       link_on,
  input  wire logic       link_busy,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic            byte_valid,
  output logic [7:0]      frame_byte,
  output logic            last,
  output logic [6:0]      space_left,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);

  logic   push, q_full, pop, q_valid;
  entry_t push_entry, head;

  tlvfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .type_high  (type_high),
    .type_low   (type_low),
    .data_value (data_value),
    .link_on    (link_on),
    .link_busy  (link_busy),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tlvfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  tlvfa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .byte_valid (byte_valid),
    .frame_byte (frame_byte),
    .last       (last),
    .space_left (space_left)
  );

endmodule
`default_nettype wire

// ===== sv/tlvfa_front.sv =====
`default_nettype none
module tlvfa_front
  import tlvfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  type_high,
  input  wire logic [7:0]  type_low,
  input  wire logic [7:0]  data_value,
  input  wire logic        link_on,
  input  wire logic        link_busy,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        q_full,
  output logic             push,
  output entry_t           push_entry
);

  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] lbi, lbi_next;
  logic [7:0]        len_val, len_val_next;
  logic              hold, hold_next;
  logic [CNT_W-1:0]  space;
  logic [ADDR_W-1:0] fill_addr;
  entry_t            e;

  always_comb begin
    space        = CNT_W'(PAYLOAD_BYTES) - fill;
    fill_addr    = fill[ADDR_W-1:0];
    fill_next    = fill;
    lbi_next     = lbi;
    len_val_next = len_val;
    hold_next    = hold;
    e            = '0;
    e.op         = OP_RESULT;
    e.status     = ST_OK;
    case (cmd_t'(cmd))
      CMD_CLEAR: begin
        if (link_busy) begin
          e.status = ST_LINK;
        end else if (hold) begin
          e.status = ST_LOCKED;
        end else begin
          e.op         = OP_CLEAR;
          fill_next    = '0;
          lbi_next     = '0;
          len_val_next = '0;
        end
      end
      CMD_NEW_TYPE: begin
        if (hold) begin
          e.status = ST_LOCKED;
        end else if (space < CNT_W'(HEADER_BYTES)) begin
          e.status = ST_FULL;
        end else begin
          e.op         = OP_WRITE;
          e.nw         = 2'd3;
          e.wa0        = fill_addr;
          e.wd0        = type_high;
          e.wa1        = fill_addr + ADDR_W'(1);
          e.wd1        = type_low;
          e.wa2        = fill_addr + ADDR_W'(2);
          e.wd2        = 8'd0;
          lbi_next     = fill_addr + ADDR_W'(2);
          fill_next    = fill + CNT_W'(HEADER_BYTES);
          len_val_next = 8'd0;
        end
      end
      CMD_ADD_BYTE: begin
        if (hold) begin
          e.status = ST_LOCKED;
        end else if (space == '0) begin
          e.status = ST_FULL;
        end else begin
          // length byte first, data word second: same address means data wins
          e.op      = OP_WRITE;
          e.nw      = 2'd2;
          e.wa0     = lbi;
          e.wd0     = len_val + 8'd1;
          e.wa1     = fill_addr;
          e.wd1     = data_value;
          fill_next = fill + CNT_W'(1);
          len_val_next = (lbi == fill_addr) ? data_value : len_val + 8'd1;
        end
      end
      CMD_SEND: begin
        if (!link_on || link_busy) begin
          e.status = ST_LINK;
        end else begin
          if (fill != '0) begin
            e.op    = OP_SEND;
            e.count = fill;
          end
          fill_next = '0;
          lbi_next  = '0;
        end
      end
      CMD_ABORT: begin
        hold_next = 1'b0;
        fill_next = '0;
        lbi_next  = '0;
      end
      default: begin
      end
    endcase
    e.space    = CNT_W'(PAYLOAD_BYTES) - fill_next;
    push_entry = e;
    in_ready   = !q_full;
    push       = in_valid && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      lbi     <= '0;
      len_val <= '0;
      hold    <= 1'b0;
    end else begin
      if (cfg_we) begin
        hold <= cfg_wdata;
      end else if (push) begin
        hold <= hold_next;
      end
      if (push) begin
        fill    <= fill_next;
        lbi     <= lbi_next;
        len_val <= len_val_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tlvfa_queue.sv =====
`default_nettype none
module tlvfa_queue
  import tlvfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  entry_t    push_entry,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output entry_t    head
);

  entry_t     q [2];
  logic       wp, rp;
  logic [1:0] count;

  always_comb begin
    full      = (count == 2'd2);
    not_empty = (count != 2'd0);
    head      = q[rp];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tlvfa_back.sv =====
`default_nettype none
module tlvfa_back
  import tlvfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  entry_t           head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             byte_valid,
  output logic [7:0]       frame_byte,
  output logic             last,
  output logic [CNT_W-1:0] space_left
);

  back_state_t         state, state_next;
  entry_t              cur;
  logic [1:0]          step, step_next;
  logic [ADDR_W-1:0]   idx, idx_next;
  logic                wr_en, clear_all, load_out, slot_free;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;
  logic [7:0]          mem [PAYLOAD_BYTES];
  logic [PAYLOAD_BYTES-1:0] vbits;
  logic [7:0]          rd_data;
  logic                rd_vld;
  status_t             o_status;
  logic                o_bv, o_last;
  logic [7:0]          o_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cur.wa0;
    wr_data    = cur.wd0;
    clear_all  = 1'b0;
    load_out   = 1'b0;
    o_status   = cur.status;
    o_bv       = 1'b0;
    o_byte     = 8'd0;
    o_last     = 1'b1;
    step_next  = step;
    idx_next   = idx;
    slot_free  = !out_valid || out_ready;
    case (state)
      B_IDLE: begin
        step_next = '0;
        idx_next  = '0;
        if (q_valid) begin
          pop = 1'b1;
          case (head.op)
            OP_WRITE: state_next = B_WRITE;
            OP_SEND:  state_next = B_SEND;
            OP_CLEAR: begin
              clear_all  = 1'b1;
              state_next = B_RESULT;
            end
            default:  state_next = B_RESULT;
          endcase
        end
      end
      B_WRITE: begin
        wr_en = 1'b1;
        case (step)
          2'd0: begin
            wr_addr = cur.wa0;
            wr_data = cur.wd0;
          end
          2'd1: begin
            wr_addr = cur.wa1;
            wr_data = cur.wd1;
          end
          default: begin
            wr_addr = cur.wa2;
            wr_data = cur.wd2;
          end
        endcase
        step_next = step + 2'd1;
        if (step == cur.nw - 2'd1) begin
          state_next = B_RESULT;
        end
      end
      B_RESULT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_SEND: begin
        if (slot_free) begin
          load_out = 1'b1;
          o_status = ST_OK;
          o_bv     = 1'b1;
          o_byte   = rd_vld ? rd_data : 8'd0;
          o_last   = (CNT_W'(idx) + CNT_W'(1)) == cur.count;
          idx_next = idx + ADDR_W'(1);
          if (o_last) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    step <= step_next;
    idx  <= idx_next;
  end

  // read runs one word ahead: the address is the index of the next cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx_next];
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (clear_all) begin
        vbits <= '0;
      end else if (wr_en) begin
        vbits[wr_addr] <= 1'b1;
      end
      rd_vld <= vbits[idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= o_status;
      byte_valid <= o_bv;
      frame_byte <= o_byte;
      last       <= o_last;
      space_left <= cur.space;
    end
  end

endmodule
`default_nettype wire
